// ===== rtl/bilinear_image_scaler_top_macros.svh =====
// Assertion macros shared by the checker of the bilinear image scaler.
`ifndef BILINEAR_IMAGE_SCALER_TOP_MACROS_SVH
`define BILINEAR_IMAGE_SCALER_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define BIS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define BIS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// Next-cycle implication that also holds across reset.
`define BIS_ASSERT_ALWAYS_NEXT(label, clk, ante, cons, msg) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/bis_pkg.sv =====
package bis_pkg;

   // Source image store geometry.
   localparam int MAX_WIDTH  = 256;
   localparam int MAX_HEIGHT = 256;
   localparam int ROW_BITS   = $clog2(MAX_HEIGHT);
   localparam int COL_BITS   = $clog2(MAX_WIDTH);
   localparam int COORD_BITS = (ROW_BITS > COL_BITS) ? ROW_BITS : COL_BITS;
   // Four banks split by row parity and column parity.
   localparam int BANK_COUNT     = 4;
   localparam int BANK_ADDR_BITS = (ROW_BITS - 1) + (COL_BITS - 1);
   localparam int BANK_DEPTH     = 1 << BANK_ADDR_BITS;

   // Field widths.
   localparam int INDEX_BITS  = 12;
   localparam int STEP_BITS   = 24;
   localparam int DIM_BITS    = 9;
   localparam int FRAC_BITS   = 16;
   localparam int PROD_BITS   = INDEX_BITS + STEP_BITS;
   localparam int CHAN_BITS   = 8;
   localparam int PIXEL_BITS  = 3 * CHAN_BITS;
   localparam int WEIGHT_BITS = 2 * FRAC_BITS + 1;
   localparam int TERM_BITS   = WEIGHT_BITS + CHAN_BITS;
   localparam int ACC_BITS    = TERM_BITS + 2;

   localparam logic [FRAC_BITS:0] ONE_FX  = {1'b1, {FRAC_BITS{1'b0}}};
   localparam logic [CHAN_BITS-1:0] OPAQUE = 8'd255;

   // Request kinds carried on the request user field.
   localparam logic ACTION_LOAD  = 1'b0;
   localparam logic ACTION_QUERY = 1'b1;

   // Configuration register indexes.
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = STEP_BITS;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_IMAGE_WIDTH  = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_IMAGE_HEIGHT = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_ROW_STEP     = 2'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_COL_STEP     = 2'd3;

   localparam logic [DIM_BITS-1:0]  DIM_RESET  = 9'd256;
   localparam logic [STEP_BITS-1:0] STEP_RESET = 24'd65536;

   // One mapped axis: floor and ceil source positions and the floor weight.
   typedef struct packed {
      logic [COORD_BITS-1:0] lo;
      logic [COORD_BITS-1:0] hi;
      logic [FRAC_BITS-1:0]  wlo;
   } axis_type;

   // Access command from the pipeline to the pixel store.
   typedef struct packed {
      logic                  wr_en;
      logic [ROW_BITS-1:0]   wr_row;
      logic [COL_BITS-1:0]   wr_col;
      logic [PIXEL_BITS-1:0] wr_pixel;
      logic                  rd_en;
      logic [ROW_BITS-1:0]   row_lo;
      logic [ROW_BITS-1:0]   row_hi;
      logic [COL_BITS-1:0]   col_lo;
      logic [COL_BITS-1:0]   col_hi;
   } store_cmd_type;

endpackage

// ===== rtl/bis_axis.sv =====
// Maps an output index to source floor/ceil positions over two stages:
// the product index * step, then the clamp and the split into position and weight.
module bis_axis (
   input  logic                                 clock,
   input  logic                                 mul_en,
   input  logic                                 map_en,
   input  logic [bis_pkg::INDEX_BITS-1:0]       index,
   input  logic [bis_pkg::STEP_BITS-1:0]        step,
   input  logic [bis_pkg::COORD_BITS-1:0]       dim_m1,
   output bis_pkg::axis_type                    axis
);

   logic [bis_pkg::PROD_BITS-1:0]  product_ff;
   logic [bis_pkg::PROD_BITS-1:0]  limit;
   logic [bis_pkg::PROD_BITS-1:0]  clamped;
   logic [bis_pkg::FRAC_BITS-1:0]  frac;
   bis_pkg::axis_type              axis_in;
   bis_pkg::axis_type              axis_ff;

   always_ff @(posedge clock) begin
      if (mul_en) begin
         product_ff <= bis_pkg::PROD_BITS'(index) * bis_pkg::PROD_BITS'(step);
      end
      if (map_en) begin
         axis_ff <= axis_in;
      end
   end

   always_comb begin
      limit   = bis_pkg::PROD_BITS'(dim_m1) << bis_pkg::FRAC_BITS;
      clamped = (product_ff > limit) ? limit : product_ff;
      frac    = clamped[bis_pkg::FRAC_BITS-1:0];
      axis_in.lo  = clamped[bis_pkg::FRAC_BITS +: bis_pkg::COORD_BITS];
      axis_in.hi  = axis_in.lo + bis_pkg::COORD_BITS'(frac != '0);
      axis_in.wlo = (frac == '0) ? '0 :
                    bis_pkg::FRAC_BITS'(bis_pkg::ONE_FX - {1'b0, frac});
   end

   assign axis = axis_ff;

endmodule

// ===== rtl/bis_store.sv =====
// Pixel store in four banks by row and column parity, so that the four
// neighbours of a query come from four different banks in the same cycle.
module bis_store (
   input  logic                                             clock,
   input  bis_pkg::store_cmd_type                           cmd,
   output logic [3:0][bis_pkg::PIXEL_BITS-1:0]              pixels
);

   logic [bis_pkg::BANK_COUNT-1:0][bis_pkg::PIXEL_BITS-1:0] rd_data;
   logic row_lo_odd_ff;
   logic row_hi_odd_ff;
   logic col_lo_odd_ff;
   logic col_hi_odd_ff;

   for (genvar b = 0; b < bis_pkg::BANK_COUNT; b++) begin : g_bank
      localparam logic ROW_ODD = (b / 2) != 0;
      localparam logic COL_ODD = (b % 2) != 0;

      logic [bis_pkg::PIXEL_BITS-1:0]     mem [bis_pkg::BANK_DEPTH];
      logic [bis_pkg::PIXEL_BITS-1:0]     rd_data_ff;
      logic [bis_pkg::ROW_BITS-1:0]       rd_row;
      logic [bis_pkg::COL_BITS-1:0]       rd_col;
      logic [bis_pkg::BANK_ADDR_BITS-1:0] rd_addr;
      logic [bis_pkg::BANK_ADDR_BITS-1:0] wr_addr;
      logic                               wr_hit;

      always_comb begin
         rd_row  = (cmd.row_lo[0] == ROW_ODD) ? cmd.row_lo : cmd.row_hi;
         rd_col  = (cmd.col_lo[0] == COL_ODD) ? cmd.col_lo : cmd.col_hi;
         rd_addr = {rd_row[bis_pkg::ROW_BITS-1:1], rd_col[bis_pkg::COL_BITS-1:1]};
         wr_addr = {cmd.wr_row[bis_pkg::ROW_BITS-1:1], cmd.wr_col[bis_pkg::COL_BITS-1:1]};
         wr_hit  = cmd.wr_en && (cmd.wr_row[0] == ROW_ODD) && (cmd.wr_col[0] == COL_ODD);
      end

      always_ff @(posedge clock) begin
         if (wr_hit) begin
            mem[wr_addr] <= cmd.wr_pixel;
         end
         if (cmd.rd_en) begin
            rd_data_ff <= mem[rd_addr];
         end
      end

      assign rd_data[b] = rd_data_ff;
   end

   always_ff @(posedge clock) begin
      if (cmd.rd_en) begin
         row_lo_odd_ff <= cmd.row_lo[0];
         row_hi_odd_ff <= cmd.row_hi[0];
         col_lo_odd_ff <= cmd.col_lo[0];
         col_hi_odd_ff <= cmd.col_hi[0];
      end
   end

   // Neighbour order: (lo,lo), (hi,lo), (lo,hi), (hi,hi) as (row,col).
   assign pixels[0] = rd_data[{row_lo_odd_ff, col_lo_odd_ff}];
   assign pixels[1] = rd_data[{row_hi_odd_ff, col_lo_odd_ff}];
   assign pixels[2] = rd_data[{row_lo_odd_ff, col_hi_odd_ff}];
   assign pixels[3] = rd_data[{row_hi_odd_ff, col_hi_odd_ff}];

endmodule

// ===== rtl/bis_blend.sv =====
// Forms the four neighbour weights, registers them with the pixels, then
// sums the weighted channels and truncates to 8 bits, saturating on overflow.
module bis_blend (
   input  logic                                       clock,
   input  logic                                       en,
   input  logic [bis_pkg::FRAC_BITS-1:0]              row_wlo,
   input  logic [bis_pkg::FRAC_BITS-1:0]              col_wlo,
   input  logic [3:0][bis_pkg::PIXEL_BITS-1:0]        pixels,
   output logic [bis_pkg::CHAN_BITS-1:0]              red,
   output logic [bis_pkg::CHAN_BITS-1:0]              green,
   output logic [bis_pkg::CHAN_BITS-1:0]              blue
);

   logic [bis_pkg::FRAC_BITS:0]                    row_whi;
   logic [bis_pkg::FRAC_BITS:0]                    col_whi;
   logic [3:0][bis_pkg::WEIGHT_BITS-1:0]           weight_in;
   logic [3:0][bis_pkg::WEIGHT_BITS-1:0]           weight_ff;
   logic [3:0][bis_pkg::PIXEL_BITS-1:0]            pixel_ff;
   logic [2:0][bis_pkg::CHAN_BITS-1:0]             chan;

   always_comb begin
      row_whi = bis_pkg::ONE_FX - {1'b0, row_wlo};
      col_whi = bis_pkg::ONE_FX - {1'b0, col_wlo};
      weight_in[0] = bis_pkg::WEIGHT_BITS'(row_wlo) * bis_pkg::WEIGHT_BITS'(col_wlo);
      weight_in[1] = bis_pkg::WEIGHT_BITS'(row_whi) * bis_pkg::WEIGHT_BITS'(col_wlo);
      weight_in[2] = bis_pkg::WEIGHT_BITS'(row_wlo) * bis_pkg::WEIGHT_BITS'(col_whi);
      weight_in[3] = bis_pkg::WEIGHT_BITS'(row_whi) * bis_pkg::WEIGHT_BITS'(col_whi);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         weight_ff <= weight_in;
         pixel_ff  <= pixels;
      end
   end

   // Channel 0 is red in the top byte of the stored pixel.
   always_comb begin
      logic [bis_pkg::ACC_BITS-1:0]  acc;
      logic [bis_pkg::CHAN_BITS-1:0] sample;
      for (int c = 0; c < 3; c++) begin
         acc = '0;
         for (int k = 0; k < 4; k++) begin
            sample = pixel_ff[k][(2 - c) * bis_pkg::CHAN_BITS +: bis_pkg::CHAN_BITS];
            acc = acc + bis_pkg::ACC_BITS'(bis_pkg::TERM_BITS'(weight_ff[k]) *
                                           bis_pkg::TERM_BITS'(sample));
         end
         if (acc[bis_pkg::ACC_BITS-1:2*bis_pkg::FRAC_BITS+bis_pkg::CHAN_BITS] != '0) begin
            chan[c] = '1;
         end else begin
            chan[c] = acc[2*bis_pkg::FRAC_BITS +: bis_pkg::CHAN_BITS];
         end
      end
   end

   assign red   = chan[0];
   assign green = chan[1];
   assign blue  = chan[2];

endmodule

// ===== rtl/bilinear_image_scaler_top.sv =====
// Channel   Direction  Payload (lowest bit first)                       Accepted when
// req       in         tdata: row_index, col_index, in_red, in_green,    req_tvalid && req_tready
//                             in_blue; tuser: action
// rsp       out        tdata: out_red, out_green, out_blue, out_alpha    rsp_tvalid && rsp_tready
// csr       in         csr_index, csr_data                               csr_valid && csr_ready
//
// One request is taken every cycle unless a stall on rsp has filled the pipeline; a query passes
// the multiply, map, bank read and weight registers, then the blend, and its response is registered.
// A load gives no response and writes the pixel store when it leaves the map stage, if it lies inside the image.
// Reset clears the pipeline valids and sets the configuration to its reset values; the pixel store needs no clearing.
// A stall on rsp only holds stages that are full, so bubbles still soak up new requests.
module bilinear_image_scaler_top (
   input  logic                                   clock,
   input  logic                                   reset,
   // Requests.
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   input  logic [47:0]                            req_tdata,  // row_index[11:0], col_index[23:12],
                                                              // in_red[31:24], in_green[39:32],
                                                              // in_blue[47:40]
   input  logic                                   req_tuser,  // action[0]
   // Responses.
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   output logic [31:0]                            rsp_tdata,  // out_red[7:0], out_green[15:8],
                                                              // out_blue[23:16], out_alpha[31:24]
   // Configuration writes.
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [bis_pkg::CSR_INDEX_BITS-1:0]     csr_index,
   input  logic [bis_pkg::CSR_DATA_BITS-1:0]      csr_data
);

   // Configuration registers.
   logic [bis_pkg::DIM_BITS-1:0]   width_ff;
   logic [bis_pkg::DIM_BITS-1:0]   height_ff;
   logic [bis_pkg::STEP_BITS-1:0]  row_step_ff;
   logic [bis_pkg::STEP_BITS-1:0]  col_step_ff;
   logic [bis_pkg::COORD_BITS-1:0] width_m1;
   logic [bis_pkg::COORD_BITS-1:0] height_m1;

   // Request fields.
   logic [bis_pkg::INDEX_BITS-1:0] req_row;
   logic [bis_pkg::INDEX_BITS-1:0] req_col;
   logic [bis_pkg::PIXEL_BITS-1:0] req_pixel;
   logic                           req_accept;

   // Stage valids and the ready chain from the response side back.
   logic valid1_ff, valid2_ff, valid3_ff, valid4_ff, rsp_valid_ff;
   logic ready1, ready2, ready3, ready4, ready_out;

   // Multiply stage payload.
   logic                           action1_ff;
   logic [bis_pkg::INDEX_BITS-1:0] row1_ff;
   logic [bis_pkg::INDEX_BITS-1:0] col1_ff;
   logic [bis_pkg::PIXEL_BITS-1:0] pixel1_ff;

   // Map stage payload.
   logic                           action2_ff;
   logic                           load_ok2_ff;
   logic [bis_pkg::ROW_BITS-1:0]   row2_ff;
   logic [bis_pkg::COL_BITS-1:0]   col2_ff;
   logic [bis_pkg::PIXEL_BITS-1:0] pixel2_ff;
   bis_pkg::axis_type              row_axis;
   bis_pkg::axis_type              col_axis;

   // Read stage payload.
   logic [bis_pkg::FRAC_BITS-1:0]  row_wlo3_ff;
   logic [bis_pkg::FRAC_BITS-1:0]  col_wlo3_ff;

   bis_pkg::store_cmd_type                     store_cmd;
   logic [3:0][bis_pkg::PIXEL_BITS-1:0]        pixels;
   logic [bis_pkg::CHAN_BITS-1:0]              blend_red;
   logic [bis_pkg::CHAN_BITS-1:0]              blend_green;
   logic [bis_pkg::CHAN_BITS-1:0]              blend_blue;
   logic [31:0]                                rsp_data_ff;

   assign req_row   = req_tdata[11:0];
   assign req_col   = req_tdata[23:12];
   assign req_pixel = {req_tdata[31:24], req_tdata[39:32], req_tdata[47:40]};

   // Configuration is always taken; software writes it only while the block is idle (not enforced by the block).
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff    <= bis_pkg::DIM_RESET;
         height_ff   <= bis_pkg::DIM_RESET;
         row_step_ff <= bis_pkg::STEP_RESET;
         col_step_ff <= bis_pkg::STEP_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            bis_pkg::CSR_IMAGE_WIDTH:  width_ff    <= csr_data[bis_pkg::DIM_BITS-1:0];
            bis_pkg::CSR_IMAGE_HEIGHT: height_ff   <= csr_data[bis_pkg::DIM_BITS-1:0];
            bis_pkg::CSR_ROW_STEP:     row_step_ff <= csr_data;
            bis_pkg::CSR_COL_STEP:     col_step_ff <= csr_data;
            default: begin
            end
         endcase
      end
   end

   // Effective dimension minus one: zero acts as one, anything above the store as its maximum.
   always_comb begin
      if (width_ff == '0) begin
         width_m1 = '0;
      end else if (32'(width_ff) > bis_pkg::MAX_WIDTH) begin
         width_m1 = bis_pkg::COORD_BITS'(bis_pkg::MAX_WIDTH - 1);
      end else begin
         width_m1 = bis_pkg::COORD_BITS'(width_ff - 1'b1);
      end
      if (height_ff == '0) begin
         height_m1 = '0;
      end else if (32'(height_ff) > bis_pkg::MAX_HEIGHT) begin
         height_m1 = bis_pkg::COORD_BITS'(bis_pkg::MAX_HEIGHT - 1);
      end else begin
         height_m1 = bis_pkg::COORD_BITS'(height_ff - 1'b1);
      end
   end

   // A stage takes a new request when it is empty or its contents move on this cycle.
   always_comb begin
      ready_out  = !rsp_valid_ff || rsp_tready;
      ready4     = !valid4_ff || ready_out;
      ready3     = !valid3_ff || ready4;
      ready2     = !valid2_ff || ready3;
      ready1     = !valid1_ff || ready2;
      req_tready = ready1;
      req_accept = req_tvalid && ready1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid1_ff    <= 1'b0;
         valid2_ff    <= 1'b0;
         valid3_ff    <= 1'b0;
         valid4_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (ready1) begin
            valid1_ff <= req_accept;
         end
         if (ready2) begin
            valid2_ff <= valid1_ff;
         end
         // Loads retire at the map stage; only queries go on to the read stage.
         if (ready3) begin
            valid3_ff <= valid2_ff && (action2_ff == bis_pkg::ACTION_QUERY);
         end
         if (ready4) begin
            valid4_ff <= valid3_ff;
         end
         if (ready_out) begin
            rsp_valid_ff <= valid4_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ready1) begin
         action1_ff <= req_tuser;
         row1_ff    <= req_row;
         col1_ff    <= req_col;
         pixel1_ff  <= req_pixel;
      end
      if (ready2) begin
         action2_ff  <= action1_ff;
         load_ok2_ff <= (32'(row1_ff) <= 32'(height_m1)) && (32'(col1_ff) <= 32'(width_m1));
         row2_ff     <= row1_ff[bis_pkg::ROW_BITS-1:0];
         col2_ff     <= col1_ff[bis_pkg::COL_BITS-1:0];
         pixel2_ff   <= pixel1_ff;
      end
      if (ready3) begin
         row_wlo3_ff <= row_axis.wlo;
         col_wlo3_ff <= col_axis.wlo;
      end
      if (ready_out) begin
         rsp_data_ff <= {bis_pkg::OPAQUE, blend_blue, blend_green, blend_red};
      end
   end

   bis_axis u_row_axis (
      .clock  (clock),
      .mul_en (ready1),
      .map_en (ready2),
      .index  (req_row),
      .step   (row_step_ff),
      .dim_m1 (height_m1),
      .axis   (row_axis)
   );

   bis_axis u_col_axis (
      .clock  (clock),
      .mul_en (ready1),
      .map_en (ready2),
      .index  (req_col),
      .step   (col_step_ff),
      .dim_m1 (width_m1),
      .axis   (col_axis)
   );

   // Loads and queries meet the store at the same stage, so a query always reads
   // after every in-range load accepted before it has been written.
   always_comb begin
      store_cmd.wr_en    = valid2_ff && ready3 && (action2_ff == bis_pkg::ACTION_LOAD) &&
                           load_ok2_ff;
      store_cmd.wr_row   = row2_ff;
      store_cmd.wr_col   = col2_ff;
      store_cmd.wr_pixel = pixel2_ff;
      store_cmd.rd_en    = valid2_ff && ready3 && (action2_ff == bis_pkg::ACTION_QUERY);
      store_cmd.row_lo   = row_axis.lo[bis_pkg::ROW_BITS-1:0];
      store_cmd.row_hi   = row_axis.hi[bis_pkg::ROW_BITS-1:0];
      store_cmd.col_lo   = col_axis.lo[bis_pkg::COL_BITS-1:0];
      store_cmd.col_hi   = col_axis.hi[bis_pkg::COL_BITS-1:0];
   end

   bis_store u_store (
      .clock  (clock),
      .cmd    (store_cmd),
      .pixels (pixels)
   );

   bis_blend u_blend (
      .clock   (clock),
      .en      (ready4),
      .row_wlo (row_wlo3_ff),
      .col_wlo (col_wlo3_ff),
      .pixels  (pixels),
      .red     (blend_red),
      .green   (blend_green),
      .blue    (blend_blue)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// ===== rtl/bis_checker.sv =====
`include "bilinear_image_scaler_top_macros.svh"

// Watches the ports of the scaler.
module bis_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_tvalid,
   input logic                                req_tready,
   input logic [47:0]                         req_tdata,
   input logic                                req_tuser,
   input logic                                rsp_tvalid,
   input logic                                rsp_tready,
   input logic [31:0]                         rsp_tdata,
   input logic                                csr_valid,
   input logic                                csr_ready,
   input logic [bis_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input logic [bis_pkg::CSR_DATA_BITS-1:0]   csr_data
);

   `BIS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready,
      rsp_tvalid && $stable(rsp_tdata), "stalled response changed or dropped")

   `BIS_ASSERT_NOW(a_alpha_opaque, clock, reset, rsp_tvalid,
      rsp_tdata[31:24] == bis_pkg::OPAQUE, "response alpha is not opaque")

   `BIS_ASSERT_NOW(a_no_needless_stall, clock, reset, !rsp_tvalid || rsp_tready,
      req_tready, "request stalled while the response side is free")

   `BIS_ASSERT_ALWAYS_NEXT(a_reset_empty, clock, reset,
      !rsp_tvalid, "response valid right after reset")

endmodule

bind bilinear_image_scaler_top bis_checker u_checker (.*);
